// ===== hdl/msgmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msgmb_pkg;

  typedef enum logic [1:0] {
    KIND_BUS_WRITE = 2'd0,
    KIND_BUS_READ  = 2'd1,
    KIND_SUBMIT    = 2'd2,
    KIND_FETCH     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_SUM  = 2'd2
  } err_t;

  localparam logic [7:0] WIRE_ERR_SUM  = 8'd255;
  localparam logic [7:0] WIRE_ERR_FULL = 8'd254;
  localparam logic [7:0] WIRE_IDLE     = 8'd0;
  localparam int         LEN_BYTE_MAX  = 255;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       starts;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/msgmb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msgmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/msgmb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msgmb_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire logic [1:0]     func,
  input  wire logic [7:0]     data,
  input  wire logic           last,
  input  wire logic           starts_read,
  output logic                item_valid,
  output msgmb_pkg::item_t    item,
  input  wire logic           item_take
);

  msgmb_pkg::item_t slots [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;
  msgmb_pkg::item_t incoming;

  always_comb begin
    incoming.kind   = msgmb_pkg::kind_t'(func);
    incoming.data   = data;
    incoming.last   = last;
    incoming.starts = starts_read & (func == msgmb_pkg::KIND_BUS_READ);
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rp];
  assign do_push    = push & ~full;
  assign do_pop     = item_take & item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= incoming;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("item queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |=> (count <= 2'd1))
    else $error("item queue grew by more than one");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (full && !item_take) |=> full)
    else $error("full dropped without a take");

endmodule
`default_nettype wire

// ===== hdl/msgmb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msgmb_back #(
  parameter int QUEUE_DEPTH     = 256,
  parameter int WRITE_FRAME_MAX = 257,
  parameter int OUT_MSG_MAX     = 253
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire msgmb_pkg::item_t item,
  output logic                  item_take,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            reply_byte,
  output logic                  reply_valid,
  output logic                  submit_rejected
);

  localparam int QA  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int WA  = $clog2(WRITE_FRAME_MAX);
  localparam int WCW = $clog2(WRITE_FRAME_MAX + 1);
  localparam int SA  = (OUT_MSG_MAX > 1) ? $clog2(OUT_MSG_MAX) : 1;
  localparam int SCW = $clog2(OUT_MSG_MAX + 2);
  localparam int RA  = $clog2(OUT_MSG_MAX + 1);
  localparam int RLW = $clog2(OUT_MSG_MAX + 2);
  localparam int CW  = $clog2(WRITE_FRAME_MAX + OUT_MSG_MAX + 2);
  localparam int NW  = $clog2(QUEUE_DEPTH + WRITE_FRAME_MAX + OUT_MSG_MAX + 4);
  localparam logic [QA-1:0] QLAST = QA'(QUEUE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_WCOPY_R, S_WCOPY_W, S_SCOPY_R, S_SCOPY_W,
    S_RCOPY_R, S_RCOPY_W, S_RTAIL, S_RWAIT, S_ROUT, S_EMIT
  } state_t;

  state_t            state;
  msgmb_pkg::item_t  itm;
  msgmb_pkg::err_t   perr;
  logic [WCW-1:0]    wcnt;
  logic [7:0]        wsum;
  logic [7:0]        wlast;
  logic [SCW-1:0]    scnt;
  logic [QA-1:0]     in_head, in_tail, out_head, out_tail;
  logic [FW-1:0]     in_fill, out_fill;
  logic              await_len;
  logic [7:0]        held_len;
  logic [RLW-1:0]    rlen, ridx;
  logic [CW-1:0]     cidx, total;
  logic [7:0]        rsum;
  logic [7:0]        res_byte;
  logic              res_rv, res_rej;
  logic              o_valid;

  logic              w_keep, w_ok, w_fit;
  logic [WCW-1:0]    w_n;
  logic [7:0]        w_sum_n, w_last_n;
  logic [CW-1:0]     w_pay;
  logic              s_keep, s_rej;
  logic [SCW-1:0]    s_n;
  logic [CW-1:0]     b_len;
  logic [7:0]        err_byte;

  logic              ws_we, ss_we, iq_we, oq_we, rb_we;
  logic [7:0]        iq_wdata, oq_wdata, rb_wdata;
  logic [RA-1:0]     rb_waddr;
  logic [7:0]        ws_rdata, ss_rdata, iq_rdata, oq_rdata, rb_rdata;

  always_comb begin
    w_keep   = wcnt < WCW'(WRITE_FRAME_MAX);
    w_n      = w_keep ? wcnt + WCW'(1) : wcnt;
    w_sum_n  = w_keep ? wsum + itm.data : wsum;
    w_last_n = w_keep ? itm.data : wlast;
    w_ok     = (w_sum_n - w_last_n) == w_last_n;
    w_pay    = CW'(w_n) - CW'(1);
    w_fit    = (w_pay <= CW'(msgmb_pkg::LEN_BYTE_MAX)) &&
               (NW'(in_fill) + NW'(w_n) <= NW'(QUEUE_DEPTH));
    s_keep   = scnt < SCW'(OUT_MSG_MAX);
    s_n      = s_keep ? scnt + SCW'(1) : SCW'(OUT_MSG_MAX + 1);
    s_rej    = (s_n > SCW'(OUT_MSG_MAX)) ||
               (NW'(out_fill) + NW'(s_n) + NW'(1) > NW'(QUEUE_DEPTH));
    b_len    = (CW'(held_len) > CW'(out_fill)) ? CW'(out_fill) : CW'(held_len);
    err_byte = (perr == msgmb_pkg::ERR_SUM) ? msgmb_pkg::WIRE_ERR_SUM
                                            : msgmb_pkg::WIRE_ERR_FULL;
  end

  always_comb begin
    ws_we    = (state == S_EXEC) && (itm.kind == msgmb_pkg::KIND_BUS_WRITE) && w_keep;
    ss_we    = (state == S_EXEC) && (itm.kind == msgmb_pkg::KIND_SUBMIT) && s_keep;
    iq_we    = 1'b0;
    iq_wdata = ws_rdata;
    oq_we    = 1'b0;
    oq_wdata = ss_rdata;
    rb_we    = 1'b0;
    rb_waddr = cidx[RA-1:0];
    rb_wdata = oq_rdata;
    case (state)
      S_EXEC: begin
        case (itm.kind)
          msgmb_pkg::KIND_BUS_WRITE: begin
            iq_we    = itm.last && (w_n != '0) && w_ok && w_fit;
            iq_wdata = 8'(w_pay);
          end
          msgmb_pkg::KIND_SUBMIT: begin
            oq_we    = itm.last && !s_rej;
            oq_wdata = 8'(s_n);
          end
          msgmb_pkg::KIND_BUS_READ: begin
            rb_waddr = '0;
            if (itm.starts) begin
              if (perr != msgmb_pkg::ERR_NONE) begin
                rb_we    = 1'b1;
                rb_wdata = err_byte;
              end else if (out_fill == '0) begin
                rb_we    = 1'b1;
                rb_wdata = msgmb_pkg::WIRE_IDLE;
              end else if (await_len) begin
                rb_we    = 1'b1;
                rb_wdata = oq_rdata;
              end
            end
          end
          default: ;
        endcase
      end
      S_WCOPY_W: iq_we = 1'b1;
      S_SCOPY_W: oq_we = 1'b1;
      S_RCOPY_W: rb_we = 1'b1;
      S_RTAIL: begin
        rb_we    = 1'b1;
        rb_waddr = total[RA-1:0];
        rb_wdata = rsum;
      end
      default: ;
    endcase
  end

  msgmb_ram #(.WIDTH(8), .DEPTH(WRITE_FRAME_MAX), .AW(WA)) u_write_stage (
    .clk(clk), .we(ws_we), .waddr(wcnt[WA-1:0]), .wdata(itm.data),
    .raddr(cidx[WA-1:0]), .rdata(ws_rdata)
  );

  msgmb_ram #(.WIDTH(8), .DEPTH(OUT_MSG_MAX), .AW(SA)) u_submit_stage (
    .clk(clk), .we(ss_we), .waddr(scnt[SA-1:0]), .wdata(itm.data),
    .raddr(cidx[SA-1:0]), .rdata(ss_rdata)
  );

  msgmb_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH), .AW(QA)) u_incoming (
    .clk(clk), .we(iq_we), .waddr(in_tail), .wdata(iq_wdata),
    .raddr(in_head), .rdata(iq_rdata)
  );

  msgmb_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH), .AW(QA)) u_outgoing (
    .clk(clk), .we(oq_we), .waddr(out_tail), .wdata(oq_wdata),
    .raddr(out_head), .rdata(oq_rdata)
  );

  msgmb_ram #(.WIDTH(8), .DEPTH(OUT_MSG_MAX + 1), .AW(RA)) u_reply (
    .clk(clk), .we(rb_we), .waddr(rb_waddr), .wdata(rb_wdata),
    .raddr(ridx[RA-1:0]), .rdata(rb_rdata)
  );

  assign item_take       = (state == S_IDLE) && item_valid;
  assign empty           = ~o_valid;

  always_ff @(posedge clk) begin
    if (item_take) itm <= item;
    if (rst) begin
      state     <= S_IDLE;
      perr      <= msgmb_pkg::ERR_NONE;
      wcnt      <= '0;
      wsum      <= '0;
      wlast     <= '0;
      scnt      <= '0;
      in_head   <= '0;
      in_tail   <= '0;
      in_fill   <= '0;
      out_head  <= '0;
      out_tail  <= '0;
      out_fill  <= '0;
      await_len <= 1'b1;
      held_len  <= '0;
      rlen      <= '0;
      ridx      <= '0;
      cidx      <= '0;
      total     <= '0;
      rsum      <= '0;
      res_byte  <= '0;
      res_rv    <= 1'b0;
      res_rej   <= 1'b0;
      o_valid   <= 1'b0;
      reply_byte      <= '0;
      reply_valid     <= 1'b0;
      submit_rejected <= 1'b0;
    end else begin
      if (o_valid && pop) o_valid <= 1'b0;
      if (iq_we) begin
        in_tail <= (in_tail == QLAST) ? '0 : in_tail + QA'(1);
        in_fill <= in_fill + FW'(1);
      end
      if (oq_we) begin
        out_tail <= (out_tail == QLAST) ? '0 : out_tail + QA'(1);
        out_fill <= out_fill + FW'(1);
      end
      case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          res_byte <= '0;
          res_rv   <= 1'b0;
          res_rej  <= 1'b0;
          case (itm.kind)
            msgmb_pkg::KIND_BUS_WRITE: begin
              state <= S_IDLE;
              if (itm.last) begin
                wcnt  <= '0;
                wsum  <= '0;
                wlast <= '0;
                if (w_n != '0) begin
                  if (!w_ok) begin
                    perr <= msgmb_pkg::ERR_SUM;
                  end else if (!w_fit) begin
                    perr <= msgmb_pkg::ERR_FULL;
                  end else if (w_pay != '0) begin
                    cidx  <= '0;
                    total <= w_pay;
                    state <= S_WCOPY_R;
                  end
                end
              end else begin
                wcnt  <= w_n;
                wsum  <= w_sum_n;
                wlast <= w_last_n;
              end
            end
            msgmb_pkg::KIND_SUBMIT: begin
              if (itm.last) begin
                scnt    <= '0;
                res_rej <= s_rej;
                if (s_rej) begin
                  state <= S_EMIT;
                end else begin
                  cidx  <= '0;
                  total <= CW'(s_n);
                  state <= S_SCOPY_R;
                end
              end else begin
                scnt  <= s_n;
                state <= S_IDLE;
              end
            end
            msgmb_pkg::KIND_BUS_READ: begin
              state <= S_ROUT;
              if (itm.starts) begin
                state <= S_RTAIL;
                total <= CW'(1);
                if (perr != msgmb_pkg::ERR_NONE) begin
                  perr <= msgmb_pkg::ERR_NONE;
                  rsum <= err_byte;
                end else if (out_fill == '0) begin
                  rsum <= msgmb_pkg::WIRE_IDLE;
                end else if (await_len) begin
                  held_len  <= oq_rdata;
                  rsum      <= oq_rdata;
                  await_len <= 1'b0;
                  out_head  <= (out_head == QLAST) ? '0 : out_head + QA'(1);
                  out_fill  <= out_fill - FW'(1) + FW'(oq_we);
                end else begin
                  await_len <= 1'b1;
                  rsum      <= '0;
                  cidx      <= '0;
                  total     <= b_len;
                  if (b_len != '0) state <= S_RCOPY_R;
                end
              end
            end
            default: begin
              state <= S_EMIT;
              if (in_fill != '0) begin
                res_byte <= iq_rdata;
                res_rv   <= 1'b1;
                in_head  <= (in_head == QLAST) ? '0 : in_head + QA'(1);
                in_fill  <= in_fill - FW'(1);
              end
            end
          endcase
        end
        S_WCOPY_R: state <= S_WCOPY_W;
        S_WCOPY_W: begin
          cidx  <= cidx + CW'(1);
          state <= (cidx + CW'(1) == total) ? S_IDLE : S_WCOPY_R;
        end
        S_SCOPY_R: state <= S_SCOPY_W;
        S_SCOPY_W: begin
          cidx  <= cidx + CW'(1);
          state <= (cidx + CW'(1) == total) ? S_EMIT : S_SCOPY_R;
        end
        S_RCOPY_R: state <= S_RCOPY_W;
        S_RCOPY_W: begin
          rsum     <= rsum + oq_rdata;
          out_head <= (out_head == QLAST) ? '0 : out_head + QA'(1);
          out_fill <= out_fill - FW'(1);
          cidx     <= cidx + CW'(1);
          state    <= (cidx + CW'(1) == total) ? S_RTAIL : S_RCOPY_R;
        end
        S_RTAIL: begin
          rlen  <= RLW'(total) + RLW'(1);
          ridx  <= '0;
          state <= S_RWAIT;
        end
        S_RWAIT: state <= S_ROUT;
        S_ROUT: begin
          state <= S_EMIT;
          if (ridx < rlen) begin
            res_byte <= rb_rdata;
            res_rv   <= 1'b1;
            ridx     <= ridx + RLW'(1);
          end
        end
        S_EMIT: begin
          if (!o_valid || pop) begin
            o_valid         <= 1'b1;
            reply_byte      <= res_byte;
            reply_valid     <= res_rv;
            submit_rejected <= res_rej;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_in_fill: assert property (@(posedge clk) disable iff (rst)
    in_fill <= FW'(QUEUE_DEPTH))
    else $error("incoming queue overfilled");
  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    out_fill <= FW'(QUEUE_DEPTH))
    else $error("outgoing queue overfilled");
  a_rej_no_data: assert property (@(posedge clk) disable iff (rst)
    (o_valid && submit_rejected) |-> !reply_valid)
    else $error("rejected submit carries reply data");
  a_ridx: assert property (@(posedge clk) disable iff (rst) ridx <= rlen)
    else $error("reply index past reply length");

endmodule
`default_nettype wire

// ===== hdl/bus_slave_message_mailbox.sv =====
// Bus-slave message mailbox.
// Input channel: push/full with func, data, last, starts_read. An item is
// taken when push is high and full is low; a two-entry item queue holds
// items ahead of the executing back end.
// Result channel: empty/pop with reply_byte, reply_valid, submit_rejected.
// Bus read and fetch items give one result; a submit item gives one only
// when last is set; bus write items give none.
// A read start that copies a message body first moves it into the reply
// buffer byte by byte before its result appears on the ports.
// Items are carried out one at a time by the back end. A frame end also
// copies its payload bytes into the incoming queue, and a final submit
// byte copies its staged bytes out into the outgoing queue.
// Reset (rst, synchronous) empties both queues, clears the error latch,
// the staging counts and the reply; memory contents are not cleared.
// When pop stays low, the finished result waits in the output register,
// the back end holds on its next result, and the item queue fills then
// raises full.
`timescale 1ns / 1ps
`default_nettype none
module bus_slave_message_mailbox #(
  parameter int QUEUE_DEPTH     = 256,
  parameter int WRITE_FRAME_MAX = 257,
  parameter int OUT_MSG_MAX     = 253
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] func,
  input  wire logic [7:0] data,
  input  wire logic       last,
  input  wire logic       starts_read,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      reply_byte,
  output logic            reply_valid,
  output logic            submit_rejected
);

  msgmb_pkg::item_t item;
  logic             item_valid;
  logic             item_take;

  msgmb_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .func(func), .data(data), .last(last), .starts_read(starts_read),
    .item_valid(item_valid), .item(item), .item_take(item_take)
  );

  msgmb_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .WRITE_FRAME_MAX(WRITE_FRAME_MAX),
    .OUT_MSG_MAX(OUT_MSG_MAX)
  ) u_back (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item(item),
    .item_take(item_take), .empty(empty), .pop(pop),
    .reply_byte(reply_byte), .reply_valid(reply_valid),
    .submit_rejected(submit_rejected)
  );

endmodule
`default_nettype wire

// ===== sim/tb_bus_slave_message_mailbox.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_bus_slave_message_mailbox;

  localparam int LIMIT = 500000;
  localparam int QDEPTH = 256;
  localparam int FRAME_MAX = 257;
  localparam int MSG_MAX = 253;

  typedef struct {
    logic [7:0] byte_val;
    logic       valid;
    logic       rejected;
  } reply_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [1:0] func;
  logic [7:0] data;
  logic       last;
  logic       starts_read;
  logic       empty;
  logic       pop;
  logic [7:0] reply_byte;
  logic       reply_valid;
  logic       submit_rejected;

  bus_slave_message_mailbox DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func), .data(data),
    .last(last), .starts_read(starts_read), .empty(empty), .pop(pop),
    .reply_byte(reply_byte), .reply_valid(reply_valid),
    .submit_rejected(submit_rejected)
  );

  msgmb_pkg::item_t pending_items[$];
  msgmb_pkg::item_t cur_item;
  reply_t expected_replies[$];

  // mailbox state mirror
  logic [7:0]      frame_buf[FRAME_MAX];
  int              frame_cnt;
  msgmb_pkg::err_t latched_err;
  logic [7:0]      in_fifo[$];
  logic [7:0]      out_fifo[$];
  logic            want_length;
  logic [7:0]      length_held;
  logic [7:0]      reply_buf[256];
  int              reply_len;
  int              reply_pos;
  logic [7:0]      submit_buf[MSG_MAX];
  int              submit_cnt;

  int  cycles;
  int  n_accepted;
  int  n_checked;
  int  n_rejects;
  int  n_wire_errs;
  int  mismatches;
  bit  taken;
  int  hold_cnt;
  bit  hold_done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit calm();
    return cycles >= 2000 && cycles < 5000;
  endfunction

  function automatic logic [7:0] pop_byte(inout logic [7:0] q[$]);
    if (q.size() == 0) return 8'd0;
    return q.pop_front();
  endfunction

  task automatic close_frame();
    int n;
    logic [7:0] sum;
    n = frame_cnt;
    sum = 0;
    if (n == 0) return;
    for (int i = 0; i + 1 < n; i++) sum += frame_buf[i];
    if (sum != frame_buf[n-1]) begin
      latched_err = msgmb_pkg::ERR_SUM;
      return;
    end
    n--;
    if (n > msgmb_pkg::LEN_BYTE_MAX || QDEPTH - in_fifo.size() < n + 1) begin
      latched_err = msgmb_pkg::ERR_FULL;
      return;
    end
    in_fifo.push_back(n[7:0]);
    for (int i = 0; i < n; i++) in_fifo.push_back(frame_buf[i]);
  endtask

  task automatic start_reply();
    int len;
    logic [7:0] sum;
    sum = 0;
    if (latched_err != msgmb_pkg::ERR_NONE) begin
      reply_buf[0] = (latched_err == msgmb_pkg::ERR_SUM) ? msgmb_pkg::WIRE_ERR_SUM
                                                         : msgmb_pkg::WIRE_ERR_FULL;
      latched_err = msgmb_pkg::ERR_NONE;
      len = 1;
    end else if (out_fifo.size() == 0) begin
      reply_buf[0] = msgmb_pkg::WIRE_IDLE;
      len = 1;
    end else if (want_length) begin
      length_held = pop_byte(out_fifo);
      reply_buf[0] = length_held;
      want_length = 0;
      len = 1;
    end else begin
      len = int'(length_held);
      if (len > out_fifo.size()) len = out_fifo.size();
      for (int i = 0; i < len; i++) reply_buf[i] = pop_byte(out_fifo);
      want_length = 1;
    end
    for (int i = 0; i < len; i++) sum += reply_buf[i];
    reply_buf[len] = sum;
    reply_len = len + 1;
    reply_pos = 0;
  endtask

  task automatic predict_item(input msgmb_pkg::item_t it);
    reply_t r;
    bit reject;
    r = '{8'd0, 1'b0, 1'b0};
    case (it.kind)
      msgmb_pkg::KIND_BUS_WRITE: begin
        if (frame_cnt < FRAME_MAX) frame_buf[frame_cnt++] = it.data;
        if (it.last) begin
          close_frame();
          frame_cnt = 0;
        end
      end
      msgmb_pkg::KIND_BUS_READ: begin
        if (it.starts) start_reply();
        if (reply_pos < reply_len) begin
          r.byte_val = reply_buf[reply_pos++];
          r.valid = 1;
        end
        expected_replies.push_back(r);
      end
      msgmb_pkg::KIND_SUBMIT: begin
        if (submit_cnt < MSG_MAX) submit_buf[submit_cnt++] = it.data;
        else submit_cnt = MSG_MAX + 1;
        if (it.last) begin
          reject = submit_cnt > MSG_MAX || QDEPTH - out_fifo.size() < submit_cnt + 1;
          if (!reject) begin
            out_fifo.push_back(submit_cnt[7:0]);
            for (int i = 0; i < submit_cnt; i++) out_fifo.push_back(submit_buf[i]);
          end
          submit_cnt = 0;
          r.rejected = reject;
          expected_replies.push_back(r);
        end
      end
      default: begin
        if (in_fifo.size() != 0) begin
          r.byte_val = in_fifo.pop_front();
          r.valid = 1;
        end
        expected_replies.push_back(r);
      end
    endcase
  endtask

  task automatic add_item(input msgmb_pkg::kind_t k, input logic [7:0] d, input logic l,
                          input logic s);
    msgmb_pkg::item_t it;
    it.kind = k;
    it.data = d;
    it.last = l;
    it.starts = s;
    pending_items.push_back(it);
  endtask

  task automatic add_frame(input int n, input bit bad);
    logic [7:0] sum;
    logic [7:0] d;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(0, 255));
      sum += d;
      add_item(msgmb_pkg::KIND_BUS_WRITE, d, 1'b0, 1'($urandom_range(0, 1)));
    end
    add_item(msgmb_pkg::KIND_BUS_WRITE, bad ? sum + 8'd1 : sum, 1'b1,
             1'($urandom_range(0, 1)));
  endtask

  task automatic add_read(input int n, input bit start);
    for (int i = 0; i < n; i++)
      add_item(msgmb_pkg::KIND_BUS_READ, 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), i == 0 && start);
  endtask

  task automatic add_submit(input int n);
    for (int i = 0; i < n; i++)
      add_item(msgmb_pkg::KIND_SUBMIT, 8'($urandom_range(0, 255)), i == n - 1,
               1'($urandom_range(0, 1)));
  endtask

  task automatic add_fetch(input int n);
    for (int i = 0; i < n; i++)
      add_item(msgmb_pkg::KIND_FETCH, 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // driver: acceptance at the rising edge, new drive at the falling edge
  always @(posedge clk) begin
    taken = 0;
    if (!rst && push && !full) begin
      predict_item(cur_item);
      n_accepted++;
      taken = 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 0;
    end else if (!(push && !taken)) begin
      if (pending_items.size() != 0 && (calm() || $urandom_range(0, 99) >= 38)) begin
        cur_item = pending_items.pop_front();
        push <= 1;
        func <= cur_item.kind;
        data <= cur_item.data;
        last <= cur_item.last;
        starts_read <= cur_item.starts;
      end else begin
        push <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && n_accepted >= 600) begin
      hold_cnt <= 700;
      hold_done <= 1;
    end
  end

  always @(negedge clk) begin
    pop <= !rst && hold_cnt == 0 && (calm() || $urandom_range(0, 99) >= 38);
  end

  // monitor
  always @(posedge clk) begin
    reply_t e;
    cycles++;
    if (!rst && pop && !empty) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %0d valid %0b rejected %0b",
                   reply_byte, reply_valid, submit_rejected);
      end else begin
        e = expected_replies.pop_front();
        n_checked++;
        if (e.rejected) n_rejects++;
        if (e.valid && (e.byte_val == msgmb_pkg::WIRE_ERR_SUM ||
                        e.byte_val == msgmb_pkg::WIRE_ERR_FULL))
          n_wire_errs++;
        if (reply_byte !== e.byte_val || reply_valid !== e.valid ||
            submit_rejected !== e.rejected) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: exp %0d/%0b/%0b got %0d/%0b/%0b",
                     n_checked, e.byte_val, e.valid, e.rejected,
                     reply_byte, reply_valid, submit_rejected);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL bus_slave_message_mailbox");
      $finish;
    end
  end

  initial begin
    int sel;
    int burst;
    rst = 1; push = 0; pop = 0; func = msgmb_pkg::KIND_FETCH; data = 0; last = 0;
    starts_read = 0;
    cycles = 0; n_accepted = 0; n_checked = 0; n_rejects = 0; n_wire_errs = 0;
    mismatches = 0; hold_cnt = 0; hold_done = 0; taken = 0;
    frame_cnt = 0; latched_err = msgmb_pkg::ERR_NONE; want_length = 1; length_held = 0;
    reply_len = 0; reply_pos = 0; submit_cnt = 0;

    // directed
    add_read(2, 0);
    add_read(2, 1);
    add_fetch(1);
    add_item(msgmb_pkg::KIND_BUS_WRITE, 8'h00, 1'b0, 1'b1);
    add_item(msgmb_pkg::KIND_BUS_WRITE, 8'hFF, 1'b0, 1'b0);
    add_item(msgmb_pkg::KIND_BUS_WRITE, 8'hFF, 1'b1, 1'b0);
    add_frame(1, 1);
    add_read(3, 1);
    add_fetch(4);
    add_item(msgmb_pkg::KIND_SUBMIT, 8'hFF, 1'b0, 1'b0);
    add_item(msgmb_pkg::KIND_SUBMIT, 8'h00, 1'b1, 1'b1);
    add_read(2, 1);
    add_read(4, 1);
    add_read(2, 1);

    // deep cases: full incoming queue, oversize frame and submit
    add_frame(255, 0);
    add_frame(2, 0);
    add_read(2, 1);
    add_fetch(260);
    add_frame(259, 0);
    add_read(2, 1);
    add_submit(254);
    add_submit(253);
    add_submit(3);
    add_read(1, 1);
    add_read(255, 1);

    while (pending_items.size() < 1600) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) add_frame($urandom_range(0, 12), 0);
      else if (sel < 38) add_frame($urandom_range(0, 12), 1);
      else if (sel < 60) add_read($urandom_range(1, 15), $urandom_range(0, 9) != 0);
      else if (sel < 80) add_submit($urandom_range(1, 12));
      else if (sel < 98) add_fetch($urandom_range(1, 10));
      else begin
        burst = $urandom_range(1, 5);
        for (int i = 0; i < burst; i++)
          add_item(msgmb_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    wait (pending_items.size() == 0 && !push && expected_replies.size() == 0);
    repeat (1000) @(posedge clk);
    $display("items accepted %0d, results checked %0d", n_accepted, n_checked);
    $display("submits rejected %0d, wire error replies %0d, mismatches %0d",
             n_rejects, n_wire_errs, mismatches);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("PASS bus_slave_message_mailbox");
    end else begin
      $display("FAIL bus_slave_message_mailbox");
    end
    $finish;
  end

endmodule
`default_nettype wire
